>>> design/gsm_pkg.sv
// Shared types and constants of the Gabor spectrum magnitude block.
// No dependencies; used by the engine and the top level.
`default_nettype none

package gsm_pkg;

    localparam int HOP_W     = 11;
    localparam int BIN_W     = 6;
    localparam int MAG_W     = 22;
    localparam int IDX_MAX_W = 6;
    localparam int CNT_MAX_W = 7;

    localparam logic [MAG_W-1:0] MAG_MAX    = 22'd4194303;
    localparam logic [HOP_W-1:0] HOP_RESET  = 11'd16;
    localparam logic [BIN_W-1:0] NBIN_RESET = 6'd33;
    localparam logic [BIN_W-1:0] NBIN_MIN   = 6'd4;

    // Configuration register indexes.
    localparam logic REG_HOP_SIZE = 1'b0;
    localparam logic REG_NUM_BINS = 1'b1;

    // Frame request from the input control to the spectrum engine.
    typedef struct packed {
        logic                 start;
        logic [IDX_MAX_W-1:0] base;
        logic [CNT_MAX_W-1:0] fill;
        logic [BIN_W-1:0]     nbins;
    } gsm_frame_req_t;

endpackage

`default_nettype wire

>>> design/gabor_spectrum_magnitude.sv
// Top level of the Gabor (Gaussian-window short-time Fourier) magnitude spectrum.
// Depends on gsm_pkg and gsm_engine (which uses gsm_rom and gsm_sqrt).
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_sample, s_end_of_signal
//   m_        out        m_valid/m_ready    m_bin_index, m_magnitude, m_last_bin
//   cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// A sample that completes no frame leaves the engine idle and s_ready high. A sample
// that completes a frame keeps s_ready low while the engine works through its nb bins,
// nb being the clamped bin count: each bin runs WIN_SIZE products through the
// single multiply-accumulate over the sample memory, then a square root that
// resolves one result bit per cycle. A stalled m_ready holds the engine at its
// result register. Reset is synchronous and active low; the sample memory has
// no reset since no sample is read before it was written.
`default_nettype none

module gabor_spectrum_magnitude #(
    parameter int WIN_SIZE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    s_sample,
    input  wire logic                             s_end_of_signal,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [gsm_pkg::BIN_W-1:0]             m_bin_index,
    output logic [gsm_pkg::MAG_W-1:0]             m_magnitude,
    output logic                                  m_last_bin,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [gsm_pkg::HOP_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(WIN_SIZE);
    localparam int CNT_W = $clog2(WIN_SIZE + 1);
    localparam logic [gsm_pkg::BIN_W-1:0] NB_MAX = gsm_pkg::BIN_W'(WIN_SIZE / 2 + 1);

    // Configuration registers.
    logic [gsm_pkg::HOP_W-1:0] hop_size_reg;
    logic [gsm_pkg::BIN_W-1:0] num_bins_reg;

    // Framing state: fill count, write pointer of the circular sample
    // memory, hop countdown and whether this signal produced a frame yet.
    logic [CNT_W-1:0]          seen_reg, seen_next;
    logic [IDX_W-1:0]          ptr_reg, ptr_next;
    logic [gsm_pkg::HOP_W-1:0] cd_reg, cd_next;
    logic                      done_reg, done_next;

    logic                      accept;
    logic                      eng_idle;
    logic                      full;
    logic [CNT_W-1:0]          seen_new;
    logic [IDX_W-1:0]          ptr_new;
    logic [gsm_pkg::HOP_W-1:0] hop_eff;
    logic [gsm_pkg::HOP_W-1:0] cd_dec;
    logic                      emit_full;
    logic                      emit_pad;
    logic [gsm_pkg::BIN_W-1:0] nb_eff;
    gsm_pkg::gsm_frame_req_t   req;

    assign accept = s_valid && s_ready;
    assign s_ready = eng_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_size_reg <= gsm_pkg::HOP_RESET;
            num_bins_reg <= gsm_pkg::NBIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gsm_pkg::REG_HOP_SIZE: hop_size_reg <= cfg_data;
                gsm_pkg::REG_NUM_BINS: num_bins_reg <= cfg_data[gsm_pkg::BIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A hop of zero behaves as one; the bin count is clamped between four and
    // what the window can resolve.
    assign hop_eff = (hop_size_reg == '0) ? gsm_pkg::HOP_W'(1) : hop_size_reg;
    assign nb_eff  = (num_bins_reg < gsm_pkg::NBIN_MIN) ? gsm_pkg::NBIN_MIN
                   : ((num_bins_reg > NB_MAX) ? NB_MAX : num_bins_reg);

    // Until the memory holds a full window, samples fill it in order from
    // address zero. After that the write pointer circles and always points
    // at the oldest sample, which is where the next frame begins.
    assign full     = seen_reg == CNT_W'(WIN_SIZE);
    assign seen_new = full ? seen_reg : seen_reg + CNT_W'(1);
    assign ptr_new  = (ptr_reg == IDX_W'(WIN_SIZE - 1)) ? '0 : ptr_reg + IDX_W'(1);
    assign cd_dec   = (cd_reg == '0) ? '0 : cd_reg - gsm_pkg::HOP_W'(1);

    always_comb begin
        emit_full = 1'b0;
        cd_next   = cd_reg;
        done_next = done_reg;
        seen_next = seen_new;
        ptr_next  = ptr_new;
        if (!done_reg) begin
            // The first frame of a signal completes on its WIN_SIZE-th sample.
            if (seen_new == CNT_W'(WIN_SIZE)) begin
                emit_full = 1'b1;
                done_next = 1'b1;
                cd_next   = hop_eff;
            end
        end else begin
            // Later frames complete every hop samples.
            if (cd_dec == '0) begin
                emit_full = 1'b1;
                cd_next   = hop_eff;
            end else begin
                cd_next   = cd_dec;
            end
        end
        // A signal that ends before its first full frame still yields one
        // frame, padded with zeros past the samples received. Any other
        // partial frame at the end is dropped.
        emit_pad = s_end_of_signal && !emit_full && !done_reg;
        if (s_end_of_signal) begin
            seen_next = '0;
            ptr_next  = '0;
            cd_next   = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            ptr_reg  <= '0;
            cd_reg   <= '0;
            done_reg <= 1'b0;
        end else if (accept) begin
            seen_reg <= seen_next;
            ptr_reg  <= ptr_next;
            cd_reg   <= cd_next;
            done_reg <= done_next;
        end
    end

    // The frame request goes out in the cycle of the transfer; the engine
    // starts reading the memory in the next cycle, after the write landed.
    always_comb begin
        req.start = accept && (emit_full || emit_pad);
        req.base  = emit_pad ? '0 : gsm_pkg::IDX_MAX_W'(ptr_new);
        req.fill  = emit_full ? gsm_pkg::CNT_MAX_W'(WIN_SIZE) : gsm_pkg::CNT_MAX_W'(seen_new);
        req.nbins = nb_eff;
    end

    gsm_engine #(
        .WIN_SIZE    (WIN_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .idle        (eng_idle),
        .wr_en       (accept),
        .wr_addr     (ptr_reg),
        .wr_data     (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_magnitude (m_magnitude),
        .m_last_bin  (m_last_bin)
    );

endmodule

`default_nettype wire

>>> design/gsm_rom.sv
// Window and twiddle tables, built at elaboration, with registered reads.
// Depends on nothing outside this file.
`default_nettype none

module gsm_rom #(
    parameter int WIN_SIZE = 64
) (
    input  wire logic                          aclk,
    input  wire logic [$clog2(WIN_SIZE)-1:0]   win_idx,
    input  wire logic [$clog2(WIN_SIZE)-1:0]   tw_idx,
    output logic      [15:0]                   win_q,
    output logic signed [15:0]                 cos_q,
    output logic signed [15:0]                 sin_q
);

    typedef longint unsigned u64_t;
    typedef logic [15:0] tab_t [WIN_SIZE];

    localparam u64_t WDEN     = u64_t'(32 * WIN_SIZE * WIN_SIZE);
    localparam longint PI_HALF = 64'd1686629713;

    function automatic u64_t div_small(u64_t a, int unsigned d);
        u64_t r;
        case (d)
            1:   r = a;
            2:   r = a / 2;
            3:   r = a / 3;
            4:   r = a / 4;
            5:   r = a / 5;
            6:   r = a / 6;
            7:   r = a / 7;
            8:   r = a / 8;
            9:   r = a / 9;
            12:  r = a / 12;
            20:  r = a / 20;
            30:  r = a / 30;
            42:  r = a / 42;
            56:  r = a / 56;
            72:  r = a / 72;
            90:  r = a / 90;
            110: r = a / 110;
            132: r = a / 132;
            156: r = a / 156;
            182: r = a / 182;
            210: r = a / 210;
            default: r = a;
        endcase
        return r;
    endfunction

    function automatic u64_t isqrt_u64(u64_t v_in);
        u64_t v;
        u64_t res;
        u64_t bw;
        v   = v_in;
        res = 0;
        bw  = u64_t'(1) << 62;
        while (bw > v) bw = bw >> 2;
        while (bw != 0) begin
            if (v >= res + bw) begin
                v   = v - (res + bw);
                res = (res >> 1) + bw;
            end else begin
                res = res >> 1;
            end
            bw = bw >> 2;
        end
        return res;
    endfunction

    function automatic u64_t gauss(int n);
        longint d;
        u64_t   v;
        u64_t   t;
        longint e;
        d = longint'(2 * n - WIN_SIZE + 1);
        v = (u64_t'(9 * d * d) << 30) / WDEN;
        t = u64_t'(1) << 30;
        e = longint'(1) << 30;
        for (int j = 1; j <= 9; j++) begin
            t = div_small((t * v) >> 30, j);
            if (j[0]) e = e - longint'(t);
            else      e = e + longint'(t);
        end
        if (e < 0) e = 0;
        for (int i = 0; i < 4; i++)
            e = longint'((u64_t'(e) * u64_t'(e) + (u64_t'(1) << 29)) >> 30);
        return u64_t'(e);
    endfunction

    function automatic u64_t win_energy();
        u64_t acc;
        u64_t g;
        acc = 0;
        for (int n = 0; n < WIN_SIZE; n++) begin
            g   = gauss(n);
            acc = acc + ((g * g) >> 20);
        end
        return acc;
    endfunction

    localparam u64_t WIN_ROOT = isqrt_u64(win_energy());

    function automatic tab_t build_win();
        tab_t t;
        u64_t g;
        u64_t val;
        for (int n = 0; n < WIN_SIZE; n++) begin
            g   = gauss(n);
            val = (WIN_ROOT != 0) ? (g * 32 + WIN_ROOT / 2) / WIN_ROOT : (g >> 15);
            t[n] = val[15:0];
        end
        return t;
    endfunction

    function automatic longint to_q15(longint s_in);
        longint s;
        longint q;
        s = (s_in < 0) ? 0 : s_in;
        q = (s + (longint'(1) << 14)) >>> 15;
        return (q > 32767) ? 32767 : q;
    endfunction

    // Twiddle value at table position n: cosine, or sine when want_sin is set.
    function automatic longint trig_val(int n, bit want_sin);
        longint t4;
        longint q;
        longint r;
        longint phi;
        u64_t   x2;
        u64_t   tc;
        u64_t   ts;
        longint sc;
        longint ss;
        longint c;
        longint s;
        longint res;
        t4  = longint'(4 * n);
        q   = t4 / WIN_SIZE;
        r   = t4 % WIN_SIZE;
        phi = PI_HALF * r / WIN_SIZE;
        x2  = (u64_t'(phi) * u64_t'(phi)) >> 30;
        tc  = u64_t'(1) << 30;
        ts  = u64_t'(phi);
        sc  = longint'(1) << 30;
        ss  = phi;
        for (int j = 1; j <= 7; j++) begin
            tc = div_small((tc * x2) >> 30, (2 * j - 1) * (2 * j));
            ts = div_small((ts * x2) >> 30, (2 * j) * (2 * j + 1));
            if (j[0]) begin
                sc = sc - longint'(tc);
                ss = ss - longint'(ts);
            end else begin
                sc = sc + longint'(tc);
                ss = ss + longint'(ts);
            end
        end
        c = to_q15(sc);
        s = to_q15(ss);
        case (q)
            0:       res = want_sin ? s  : c;
            1:       res = want_sin ? c  : -s;
            2:       res = want_sin ? -s : -c;
            default: res = want_sin ? -c : s;
        endcase
        return res;
    endfunction

    function automatic tab_t build_trig(bit want_sin);
        tab_t   t;
        longint v;
        for (int n = 0; n < WIN_SIZE; n++) begin
            v    = trig_val(n, want_sin);
            t[n] = v[15:0];
        end
        return t;
    endfunction

    localparam tab_t WIN_TAB = build_win();
    localparam tab_t COS_TAB = build_trig(1'b0);
    localparam tab_t SIN_TAB = build_trig(1'b1);

    always_ff @(posedge aclk) begin
        win_q <= WIN_TAB[win_idx];
        cos_q <= $signed(COS_TAB[tw_idx]);
        sin_q <= $signed(SIN_TAB[tw_idx]);
    end

endmodule

`default_nettype wire

>>> design/gsm_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing outside this file.
`default_nettype none

module gsm_sqrt #(
    parameter int ROOT_W = 27
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   rad,
    output logic                       done,
    output logic      [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(ROOT_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> design/gsm_engine.sv
// Spectrum engine: sample memory, shared multiply-accumulate, magnitude and result register.
// Depends on gsm_pkg, gsm_rom and gsm_sqrt.
`default_nettype none

module gsm_engine #(
    parameter int WIN_SIZE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire gsm_pkg::gsm_frame_req_t         req,
    output logic                                 idle,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(WIN_SIZE)-1:0]     wr_addr,
    input  wire logic signed [SAMPLE_BITS-1:0]   wr_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gsm_pkg::BIN_W-1:0]            m_bin_index,
    output logic [gsm_pkg::MAG_W-1:0]            m_magnitude,
    output logic                                 m_last_bin
);

    localparam int IDX_W  = $clog2(WIN_SIZE);
    localparam int CNT_W  = $clog2(WIN_SIZE + 1);
    localparam int XW_W   = SAMPLE_BITS + 17;
    localparam int PR_W   = XW_W + 16;
    localparam int ACC_W  = PR_W + IDX_W;
    localparam int AR_W   = ACC_W - 29;
    localparam int ROOT_W = AR_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SAT_W  = ROOT_W + gsm_pkg::MAG_W;
    localparam logic [ACC_W:0] RND = (ACC_W + 1)'(1) << 29;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MAC    = 8'b0000_0010,
        S_DRAIN  = 8'b0000_0100,
        S_ROUND  = 8'b0000_1000,
        S_SQUARE = 8'b0001_0000,
        S_LAUNCH = 8'b0010_0000,
        S_SQRT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } eng_state_t;

    eng_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] mem [WIN_SIZE];

    logic [IDX_W-1:0]             base_reg;
    logic [CNT_W-1:0]             fill_reg;
    logic [gsm_pkg::BIN_W-1:0]    nb_reg;
    logic [gsm_pkg::BIN_W-1:0]    k_reg;
    logic [IDX_W-1:0]             n_reg;
    logic [IDX_W-1:0]             addr_reg;
    logic [IDX_W-1:0]             p_reg;

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         m1_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic signed [XW_W-1:0]       xw_reg;
    logic signed [15:0]           c2_reg, s2_reg;
    logic signed [PR_W-1:0]       pr_reg, pi_reg;
    logic signed [ACC_W-1:0]      acc_re_reg, acc_im_reg;
    logic [AR_W-1:0]              ar_reg, ai_reg;
    logic [2*AR_W-1:0]            sqr_reg, sqi_reg;

    logic                         m_valid_reg;
    logic [gsm_pkg::BIN_W-1:0]    m_bin_reg;
    logic [gsm_pkg::MAG_W-1:0]    m_mag_reg;
    logic                         m_last_reg;

    logic [15:0]                  win_q;
    logic signed [15:0]           cos_q, sin_q;
    logic                         sq_done;
    logic [ROOT_W-1:0]            sq_root;

    logic [IDX_W:0]               p_sum;
    logic [IDX_W-1:0]             p_step;
    logic [IDX_W-1:0]             addr_step;
    logic [ACC_W-1:0]             abs_re, abs_im;
    logic [ACC_W:0]               rnd_re, rnd_im;
    logic [RAD_W-1:0]             radicand;
    logic [SAT_W-1:0]             root_wide;
    logic [gsm_pkg::MAG_W-1:0]    mag_sat;
    logic                         out_free;
    logic                         last_k;

    gsm_rom #(.WIN_SIZE(WIN_SIZE)) u_rom (
        .aclk    (aclk),
        .win_idx (n_reg),
        .tw_idx  (p_reg),
        .win_q   (win_q),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    gsm_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_LAUNCH),
        .rad     (radicand),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Phase and address both advance modulo the window length.
    assign p_sum     = {1'b0, p_reg} + (IDX_W + 1)'(k_reg);
    assign p_step    = (p_sum >= (IDX_W + 1)'(WIN_SIZE))
                     ? IDX_W'(p_sum - (IDX_W + 1)'(WIN_SIZE)) : IDX_W'(p_sum);
    assign addr_step = (addr_reg == IDX_W'(WIN_SIZE - 1)) ? '0 : addr_reg + IDX_W'(1);

    assign abs_re = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign abs_im = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign rnd_re = {1'b0, abs_re} + RND;
    assign rnd_im = {1'b0, abs_im} + RND;

    assign radicand  = RAD_W'(sqr_reg) + RAD_W'(sqi_reg);
    assign root_wide = SAT_W'(sq_root);
    assign mag_sat   = (root_wide > SAT_W'(gsm_pkg::MAG_MAX)) ? gsm_pkg::MAG_MAX
                     : root_wide[gsm_pkg::MAG_W-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign last_k   = k_reg == nb_reg - gsm_pkg::BIN_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req.start) state_next = S_MAC;
            S_MAC:    if (n_reg == IDX_W'(WIN_SIZE - 1)) state_next = S_DRAIN;
            S_DRAIN:  if (!v1_reg && !v2_reg && !v3_reg) state_next = S_ROUND;
            S_ROUND:  state_next = S_SQUARE;
            S_SQUARE: state_next = S_LAUNCH;
            S_LAUNCH: state_next = S_SQRT;
            S_SQRT:   if (sq_done) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = last_k ? S_IDLE : S_MAC;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= state_reg == S_MAC;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Bin sequencing and frame parameters.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                base_reg <= IDX_W'(req.base);
                fill_reg <= CNT_W'(req.fill);
                nb_reg   <= req.nbins;
                k_reg    <= '0;
                n_reg    <= '0;
                p_reg    <= '0;
                addr_reg <= IDX_W'(req.base);
            end
            S_MAC: begin
                n_reg    <= n_reg + IDX_W'(1);
                p_reg    <= p_step;
                addr_reg <= addr_step;
            end
            S_OUT: begin
                if (out_free) begin
                    k_reg    <= k_reg + gsm_pkg::BIN_W'(1);
                    n_reg    <= '0;
                    p_reg    <= '0;
                    addr_reg <= base_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[addr_reg];
    end

    // Multiply-accumulate pipeline: read, window, twiddle, accumulate.
    always_ff @(posedge aclk) begin
        m1_reg <= CNT_W'(n_reg) < fill_reg;
        xw_reg <= m1_reg ? rd_reg * $signed({1'b0, win_q}) : $signed(XW_W'(0));
        c2_reg <= cos_q;
        s2_reg <= sin_q;
        pr_reg <= xw_reg * c2_reg;
        pi_reg <= xw_reg * s2_reg;
        if ((state_reg == S_IDLE) || (state_reg == S_OUT)) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (v3_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(pr_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(pi_reg);
        end
        if (state_reg == S_ROUND) begin
            ar_reg <= rnd_re[ACC_W:30];
            ai_reg <= rnd_im[ACC_W:30];
        end
        if (state_reg == S_SQUARE) begin
            sqr_reg <= ar_reg * ar_reg;
            sqi_reg <= ai_reg * ai_reg;
        end
        if (state_reg == S_OUT && out_free) begin
            m_bin_reg  <= k_reg;
            m_mag_reg  <= mag_sat;
            m_last_reg <= last_k;
        end
    end

    assign idle        = state_reg == S_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_reg;
    assign m_magnitude = m_mag_reg;
    assign m_last_bin  = m_last_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for gabor_spectrum_magnitude: random and directed sample streams
// checked bin by bin against a predictor built into the scoreboard class.
// Depends on gsm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;

    localparam int WIN        = 64;
    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_LEN   = 3000;

    // A spectrum scoreboard: it mirrors the framing state of the block, computes
    // the magnitude bins of every completed frame, and checks the results.
    class spectrum_scoreboard;
        typedef struct {
            logic [gsm_pkg::BIN_W-1:0] bin;
            logic [gsm_pkg::MAG_W-1:0] mag;
            logic                      last;
        } bin_result_t;

        longint        win_q15[WIN];
        longint        cos_q15[WIN];
        longint        sin_q15[WIN];
        longint        frame_buf[WIN];
        int            fill_cnt;
        int            hop_left;
        bit            frame_emitted;
        int            hop_reg;
        int            nbins_reg;
        bin_result_t   pending_bins[$];
        int            errors;
        int            frames;
        int            bins_checked;

        function new();
            longint unsigned g[WIN];
            longint unsigned energy, root, v, t, x2, tc, ts;
            longint          d, e, phi, sc, ss, c, s, q, r;
            errors = 0;
            frames = 0;
            bins_checked = 0;
            energy = 0;
            // Gaussian window as a truncated series, raised to the 16th power.
            for (int n = 0; n < WIN; n++) begin
                d = 2 * n - WIN + 1;
                v = (longint'(9 * d * d) << 30) / (32 * WIN * WIN);
                t = 64'd1 << 30;
                e = 64'sd1 << 30;
                for (int j = 1; j <= 9; j++) begin
                    t = ((t * v) >> 30) / j;
                    if (j % 2) e -= longint'(t); else e += longint'(t);
                end
                if (e < 0) e = 0;
                for (int i = 0; i < 4; i++)
                    e = longint'((longint'(e) * longint'(e) + (64'd1 << 29)) >> 30);
                g[n] = e;
                energy += (g[n] * g[n]) >> 20;
            end
            root = int_sqrt(energy);
            for (int n = 0; n < WIN; n++)
                win_q15[n] = (root != 0) ? longint'((g[n] * 32 + root / 2) / root)
                                         : longint'(g[n] >> 15);
            // Twiddles: a first-quadrant Taylor series mapped to the quadrant.
            for (int n = 0; n < WIN; n++) begin
                q = (4 * n) / WIN;
                r = (4 * n) % WIN;
                phi = 64'sd1686629713 * r / WIN;
                x2 = (longint'(phi) * longint'(phi)) >> 30;
                tc = 64'd1 << 30;
                ts = phi;
                sc = 64'sd1 << 30;
                ss = phi;
                for (int j = 1; j <= 7; j++) begin
                    tc = ((tc * x2) >> 30) / ((2 * j - 1) * (2 * j));
                    ts = ((ts * x2) >> 30) / ((2 * j) * (2 * j + 1));
                    if (j % 2) begin
                        sc -= longint'(tc);
                        ss -= longint'(ts);
                    end else begin
                        sc += longint'(tc);
                        ss += longint'(ts);
                    end
                end
                c = to_q15(sc);
                s = to_q15(ss);
                case (q)
                    0: begin cos_q15[n] = c;  sin_q15[n] = s;  end
                    1: begin cos_q15[n] = -s; sin_q15[n] = c;  end
                    2: begin cos_q15[n] = -c; sin_q15[n] = -s; end
                    default: begin cos_q15[n] = s; sin_q15[n] = -c; end
                endcase
            end
            foreach (frame_buf[i]) frame_buf[i] = 0;
            fill_cnt = 0;
            hop_left = 0;
            frame_emitted = 0;
            hop_reg = gsm_pkg::HOP_RESET;
            nbins_reg = gsm_pkg::NBIN_RESET;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned val);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > val) bitv >>= 2;
            while (bitv != 0) begin
                if (val >= res + bitv) begin
                    val -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        static function longint to_q15(longint s);
            longint qv;
            if (s < 0) s = 0;
            qv = (s + (64'sd1 << 14)) >>> 15;
            return (qv > 32767) ? 32767 : qv;
        endfunction

        function void write_reg(logic idx, int value);
            if (idx == gsm_pkg::REG_HOP_SIZE) hop_reg = value & 11'h7FF;
            else nbins_reg = value & 6'h3F;
        endfunction

        function int eff_hop();
            return (hop_reg == 0) ? 1 : hop_reg;
        endfunction

        function void compute_frame(int filled);
            int              nb;
            longint          re, im, xw;
            longint unsigned ar, ai, mag;
            bin_result_t     res;
            nb = (nbins_reg < gsm_pkg::NBIN_MIN) ? gsm_pkg::NBIN_MIN : nbins_reg;
            if (nb > WIN / 2 + 1) nb = WIN / 2 + 1;
            frames++;
            for (int k = 0; k < nb; k++) begin
                re = 0;
                im = 0;
                for (int n = 0; n < WIN && n < filled; n++) begin
                    xw = frame_buf[n] * win_q15[n];
                    re += xw * cos_q15[(k * n) % WIN];
                    im -= xw * sin_q15[(k * n) % WIN];
                end
                ar = (longint'(re < 0 ? -re : re) + (64'd1 << 29)) >> 30;
                ai = (longint'(im < 0 ? -im : im) + (64'd1 << 29)) >> 30;
                mag = int_sqrt(ar * ar + ai * ai);
                if (mag > gsm_pkg::MAG_MAX) mag = gsm_pkg::MAG_MAX;
                res.bin = gsm_pkg::BIN_W'(k);
                res.mag = gsm_pkg::MAG_W'(mag);
                res.last = (k + 1 == nb);
                pending_bins.push_back(res);
            end
        endfunction

        // Called for every sample transfer accepted by the block.
        function void note_sample(logic signed [15:0] smp, logic eos);
            bit emitted;
            emitted = 0;
            if (fill_cnt < WIN) begin
                frame_buf[fill_cnt] = smp;
                fill_cnt++;
            end else begin
                for (int i = 0; i < WIN - 1; i++) frame_buf[i] = frame_buf[i + 1];
                frame_buf[WIN - 1] = smp;
            end
            if (!frame_emitted) begin
                if (fill_cnt == WIN) begin
                    compute_frame(WIN);
                    emitted = 1;
                    frame_emitted = 1;
                    hop_left = eff_hop();
                end
            end else begin
                if (hop_left > 0) hop_left--;
                if (hop_left == 0) begin
                    compute_frame(WIN);
                    emitted = 1;
                    hop_left = eff_hop();
                end
            end
            if (eos) begin
                // A signal too short for a full frame still yields one padded frame.
                if (!emitted && !frame_emitted) compute_frame(fill_cnt);
                fill_cnt = 0;
                hop_left = 0;
                frame_emitted = 0;
            end
        endfunction

        // Called for every result transfer.
        function void check_bin(logic [gsm_pkg::BIN_W-1:0] bin,
                                logic [gsm_pkg::MAG_W-1:0] mag, logic last);
            bin_result_t want;
            if (pending_bins.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected bin %0d magnitude %0d last %0b",
                             $realtime, bin, mag, last);
                return;
            end
            want = pending_bins.pop_front();
            bins_checked++;
            if (want.bin !== bin || want.mag !== mag || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: bin mismatch, expected %0d/%0d/%0b got %0d/%0d/%0b",
                             $realtime, want.bin, want.mag, want.last, bin, mag, last);
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [15:0]            s_sample;
    logic                          s_end_of_signal;
    logic                          m_valid;
    logic                          m_ready;
    logic [gsm_pkg::BIN_W-1:0]     m_bin_index;
    logic [gsm_pkg::MAG_W-1:0]     m_magnitude;
    logic                          m_last_bin;
    logic                          cfg_wr_en;
    logic                          cfg_index;
    logic [gsm_pkg::HOP_W-1:0]     cfg_data;

    spectrum_scoreboard sb;
    bit hold_req;
    int burst_left;
    int samples_sent;
    int signals_sent;
    int idle_cycles;

    gabor_spectrum_magnitude #(.WIN_SIZE(WIN), .SAMPLE_BITS(16)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_end_of_signal(s_end_of_signal),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_bin_index(m_bin_index), .m_magnitude(m_magnitude), .m_last_bin(m_last_bin),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 0;
    always #1 aclk = ~aclk;

    // Every result transfer is checked at the rising edge where it happens.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_bin(m_bin_index, m_magnitude, m_last_bin);
    end

    // The watchdog counts cycles without any transfer or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The result side stalls on its own pattern: its mode is drawn at random
    // from always ready, coin-flip ready and mostly stalled. On a request it
    // holds off for a long stretch so that the engine backs up and the sample
    // input stalls behind it.
    initial begin
        int mode;
        int mode_left;
        m_ready = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(2);
                mode_left = 50;
            end
            mode_left--;
            case (mode)
                0: m_ready = 1;
                1: m_ready = $urandom_range(1);
                default: m_ready = ($urandom_range(3) == 0);
            endcase
        end
    end

    // Offers one sample and waits for its transfer. Entered and left at a
    // falling edge. The sender works in bursts with random gaps between them.
    task automatic send_sample(input logic signed [15:0] smp, input logic eos);
        s_valid = 1;
        s_sample = smp;
        s_end_of_signal = eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(smp, eos);
        samples_sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid = 0;
            repeat ($urandom_range(6)) @(negedge aclk);
            burst_left = $urandom_range(20);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $signed(16'($urandom_range(15))) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_signal(input int len);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
        signals_sent++;
    endtask

    // Waits at falling edges until every predicted bin has been delivered.
    task automatic wait_drained();
        while (sb.pending_bins.size() != 0) @(negedge aclk);
    endtask

    // Registers change only once the block has delivered every bin and had
    // time to settle.
    task automatic write_reg(input logic idx, input int value);
        s_valid = 0;
        wait_drained();
        @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_data = gsm_pkg::HOP_W'(value);
        @(negedge aclk);
        cfg_wr_en = 0;
        sb.write_reg(idx, value);
    endtask

    // Random signals: a mix of short signals, signals that end exactly on a
    // frame, and longer ones that leave a trailing partial frame. The last
    // signal of a phase is cut to what is left of the sample budget.
    task automatic random_phase(input int budget);
        int used;
        int len;
        used = 0;
        while (used < budget) begin
            case ($urandom_range(5))
                0: len = $urandom_range(20, 1);
                1: len = WIN;
                2: len = WIN + sb.eff_hop() * $urandom_range(3, 1);
                3: len = $urandom_range(120, 65);
                default: len = $urandom_range(150, 1);
            endcase
            if (len > 150) len = 150;
            if (len > budget - used) len = budget - used;
            send_signal(len);
            used += len;
        end
    endtask

    initial begin
        logic signed [15:0] edge_vals[4];
        edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
        sb = new();
        hold_req = 0;
        burst_left = 0;
        samples_sent = 0;
        signals_sent = 0;
        idle_cycles = 0;
        s_valid = 0;
        s_sample = 0;
        s_end_of_signal = 0;
        cfg_wr_en = 0;
        cfg_index = gsm_pkg::REG_HOP_SIZE;
        cfg_data = 0;
        aresetn = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed: a one-sample signal padded to a frame, a short signal of
        // extreme values, then one that ends exactly on its first full frame.
        send_sample(16'sh7FFF, 1);
        for (int i = 0; i < 4; i++) send_sample(edge_vals[i], i == 3);
        for (int i = 0; i < WIN; i++) send_sample(edge_vals[i % 2], i == WIN - 1);
        signals_sent += 3;
        random_phase(10);

        write_reg(gsm_pkg::REG_HOP_SIZE, 1);
        write_reg(gsm_pkg::REG_NUM_BINS, 4);
        random_phase(60);

        // Zero acts as the smallest hop and a bin count below four as four.
        write_reg(gsm_pkg::REG_HOP_SIZE, 0);
        write_reg(gsm_pkg::REG_NUM_BINS, 0);
        random_phase(50);

        write_reg(gsm_pkg::REG_HOP_SIZE, 1024);
        write_reg(gsm_pkg::REG_NUM_BINS, 63);
        random_phase(64);

        write_reg(gsm_pkg::REG_HOP_SIZE, 2047);
        write_reg(gsm_pkg::REG_NUM_BINS, 33);
        random_phase(10);

        // Long receiver hold-off while samples keep coming.
        write_reg(gsm_pkg::REG_HOP_SIZE, 5);
        write_reg(gsm_pkg::REG_NUM_BINS, 17);
        hold_req = 1;
        random_phase(70);

        write_reg(gsm_pkg::REG_HOP_SIZE, 3);
        write_reg(gsm_pkg::REG_NUM_BINS, 33);
        random_phase(30);

        s_valid = 0;
        wait_drained();
        repeat (200) @(negedge aclk);
        $display("Sent %0d samples in %0d signals over seven register settings.",
                 samples_sent, signals_sent);
        $display("Predicted %0d frames and checked %0d bins, %0d mismatches.",
                 sb.frames, sb.bins_checked, sb.errors);
        if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/gsm_pkg.sv
design/gsm_rom.sv
design/gsm_sqrt.sv
design/gsm_engine.sv
design/gabor_spectrum_magnitude.sv
tb/tb.sv
